// ===== rtl/core/grc_pkg.sv =====
// shared types, constants and helper functions for the reachability checker
`default_nettype none

package grc_pkg;

  localparam int unsigned MAX_NODES = 16;
  localparam int unsigned NODE_W    = $clog2(MAX_NODES);
  localparam int unsigned CNT_W     = $clog2(MAX_NODES + 1);

  typedef logic [MAX_NODES-1:0] node_mask_t;
  typedef logic [NODE_W-1:0]    node_id_t;
  typedef logic [CNT_W-1:0]     node_cnt_t;

  // one input word: a row of the adjacency matrix
  typedef struct packed {
    logic [3:0]  row_index;
    logic [15:0] row_mask;
    logic        last_row;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic        all_reached;
    logic [4:0]  reached_count;
    logic [15:0] reached_mask;
  } out_word_t;

  // search launch from the top level
  typedef struct packed {
    logic       go;
    node_mask_t in_use;
  } search_cmd_t;

  // read request toward the adjacency memory
  typedef struct packed {
    logic     en;
    node_id_t addr;
  } rd_req_t;

  // mask of the nodes below the active count, with the count clamped to 1..MAX_NODES
  function automatic node_mask_t in_use_mask(input logic [4:0] count);
    node_mask_t m;
    logic [4:0] n;
    n = count;
    if (n == 5'd0) begin
      n = 5'd1;
    end
    for (int i = 0; i < int'(MAX_NODES); i++) begin
      m[i] = (5'(i) < n);
    end
    return m;
  endfunction

  function automatic logic [2:0] nibble_ones(input logic [3:0] v);
    logic [2:0] c;
    case (v)
      4'h0:                      c = 3'd0;
      4'h1, 4'h2, 4'h4, 4'h8:    c = 3'd1;
      4'h7, 4'hB, 4'hD, 4'hE:    c = 3'd3;
      4'hF:                      c = 3'd4;
      default:                   c = 3'd2;
    endcase
    return c;
  endfunction

  // population count as a sum of nibble counts
  function automatic node_cnt_t count_ones(input node_mask_t m);
    node_cnt_t total;
    total = '0;
    for (int k = 0; k < int'(MAX_NODES) / 4; k++) begin
      total = total + node_cnt_t'(nibble_ones(m[k*4 +: 4]));
    end
    return total;
  endfunction

  // index of the lowest set bit, zero when none is set
  function automatic node_id_t lowest_one(input node_mask_t m);
    node_id_t idx;
    idx = '0;
    for (int i = int'(MAX_NODES) - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = node_id_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/graph_reachability_check.sv =====
// top level of the graph reachability checker: row loading, config and search
//
//  channel  dir  handshake               word
//  in_      in   start & !busy           in_word: row_index, row_mask, last_row
//  out_     out  out_strobe (one cycle)  out_word: all_reached, reached_count, reached_mask
//  cfg_     in   cfg_valid & cfg_ready   cfg_data: node_count
//
//  a row word is written into the adjacency memory at the accepting edge
//  a last-row word then runs the search: one memory read per reached node, one per cycle;
//  busy stays high while the search runs, and the result strobes in the cycle busy falls
//  rst_n (synchronous, active low) sets node_count to 16 and leaves the matrix unwritten
//  the receiver cannot stall: each result is shown for exactly one cycle
`default_nettype none

module graph_reachability_check (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire grc_pkg::in_word_t  in_word,
  output logic                    out_strobe,
  output grc_pkg::out_word_t      out_word,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [4:0]         cfg_data
);
  import grc_pkg::*;

  logic        accept;
  logic [4:0]  node_count_r;
  logic [4:0]  node_count_nxt;
  search_cmd_t cmd;
  rd_req_t     rd_req;
  node_mask_t  rd_data;
  node_mask_t  cfg_clamped;

  // a word is taken whenever the search is not running
  assign accept    = start & ~busy;
  // config only lands between searches
  assign cfg_ready = ~busy;

  // node_count register, clamped into 1..MAX_NODES on use
  always_comb begin
    node_count_nxt = node_count_r;
    if (cfg_valid && cfg_ready) begin
      node_count_nxt = cfg_data;
    end
    if (node_count_r > 5'(MAX_NODES)) begin
      cfg_clamped = in_use_mask(5'(MAX_NODES));
    end else begin
      cfg_clamped = in_use_mask(node_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 5'd16;
    end else begin
      node_count_r <= node_count_nxt;
    end
  end

  // last row goes into memory at the same edge the first read (row 0) launches; the memory forwards it if it is row 0
  assign cmd.go     = accept & in_word.last_row;
  assign cmd.in_use = cfg_clamped;

  grc_adj_ram u_adj_ram (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (node_id_t'(in_word.row_index)),
    .wr_data (node_mask_t'(in_word.row_mask)),
    .rd_req  (rd_req),
    .rd_data (rd_data)
  );

  grc_search u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .rd_req     (rd_req),
    .rd_data    (rd_data),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

`default_nettype wire

// ===== rtl/core/grc_adj_ram.sv =====
// adjacency matrix storage, one row per entry, synchronous read
`default_nettype none

module grc_adj_ram (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire grc_pkg::node_id_t   wr_addr,
  input  wire grc_pkg::node_mask_t wr_data,
  input  wire grc_pkg::rd_req_t    rd_req,
  output grc_pkg::node_mask_t      rd_data
);
  import grc_pkg::*;

  node_mask_t mem [MAX_NODES];
  node_mask_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // a read of the row written on the same edge returns the new row
  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      if (wr_en && (wr_addr == rd_req.addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_req.addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/grc_search.sv =====
// reachability search sequencer: visited and pending sets, one row expanded per cycle
`default_nettype none

module grc_search (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire grc_pkg::search_cmd_t cmd,
  output grc_pkg::rd_req_t         rd_req,
  input  wire grc_pkg::node_mask_t rd_data,
  output logic                     busy,
  output logic                     out_strobe,
  output grc_pkg::out_word_t       out_word
);
  import grc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_EXPAND = 2'b10
  } state_t;

  state_t     state_r, state_nxt;
  node_mask_t visited_r, visited_nxt;
  node_mask_t pending_r, pending_nxt;
  node_mask_t in_use_r, in_use_nxt;
  logic       out_strobe_r, out_strobe_nxt;
  out_word_t  out_word_r, out_word_nxt;

  node_mask_t fresh;
  node_mask_t visited_grow;
  node_mask_t pending_grow;

  always_comb begin
    fresh        = rd_data & in_use_r & ~visited_r;
    visited_grow = visited_r | fresh;
    pending_grow = pending_r | fresh;

    state_nxt      = state_r;
    visited_nxt    = visited_r;
    pending_nxt    = pending_r;
    in_use_nxt     = in_use_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    rd_req.en      = 1'b0;
    rd_req.addr    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd.go) begin
          // node 0 is reached by definition and expanded first
          visited_nxt = node_mask_t'(1);
          pending_nxt = '0;
          in_use_nxt  = cmd.in_use;
          rd_req.en   = 1'b1;
          rd_req.addr = '0;
          state_nxt   = S_EXPAND;
        end
      end
      S_EXPAND: begin
        visited_nxt = visited_grow;
        if (pending_grow == '0) begin
          out_strobe_nxt             = 1'b1;
          out_word_nxt.all_reached   = (visited_grow == in_use_r);
          out_word_nxt.reached_count = count_ones(visited_grow);
          out_word_nxt.reached_mask  = visited_grow;
          pending_nxt                = '0;
          state_nxt                  = S_IDLE;
        end else begin
          // pop the lowest pending node and fetch its row
          pending_nxt = pending_grow & (pending_grow - node_mask_t'(1));
          rd_req.en   = 1'b1;
          rd_req.addr = lowest_one(pending_grow);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      visited_r    <= '0;
      pending_r    <= '0;
      in_use_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      visited_r    <= visited_nxt;
      pending_r    <= pending_nxt;
      in_use_r     <= in_use_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  a_node0_visited: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXPAND) |-> visited_r[0])
    else $error("node 0 not marked visited during search");

  a_pending_subset: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r & ~visited_r) == '0)
    else $error("pending node not in visited set");

  a_visited_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXPAND) |-> ((visited_r & ~in_use_r) == '0))
    else $error("visited node outside active range");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r)
    else $error("result strobe held more than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r == S_EXPAND))
    else $error("result without a finished search");

endmodule

`default_nettype wire
